// File: design/drlt_pkg.sv
// Shared types, register map and constants of the display register and line timer block.
package drlt_pkg;

  localparam int unsigned LINE_W          = 8;
  localparam int unsigned LinesPerFrameDef = 159;
  localparam int unsigned VisibleLinesDef  = 144;
  localparam logic [7:0]  LINE_RESET      = 8'd145;

  localparam int unsigned DISP_DEPTH      = 22;
  localparam int unsigned DISP_IDX_W      = 5;
  localparam int unsigned GRAY_DEPTH      = 4;
  localparam int unsigned PAL_DEPTH       = 32;
  localparam int unsigned PAL_W           = 6;
  localparam int unsigned TMR_W           = 16;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register map
  localparam logic [7:0] ADDR_DISP_LAST = 8'h15;
  localparam logic [7:0] ADDR_LINE      = 8'h02;
  localparam logic [7:0] ADDR_LINE_CMP  = 8'h03;
  localparam logic [7:0] ADDR_MASKED    = 8'h04;
  localparam logic [5:0] ADDR_GRAY_HI   = 6'h07;   // 0x1C..0x1F
  localparam logic [2:0] ADDR_PAL_HI    = 3'b001;  // 0x20..0x3F
  localparam logic [7:0] ADDR_VMODE     = 8'h60;
  localparam logic [7:0] ADDR_ID        = 8'hA0;
  localparam logic [7:0] ADDR_TCTL      = 8'hA2;
  localparam logic [7:0] ADDR_HB_LO     = 8'hA4;
  localparam logic [7:0] ADDR_HB_HI     = 8'hA5;
  localparam logic [7:0] ADDR_VB_LO     = 8'hA6;
  localparam logic [7:0] ADDR_VB_HI     = 8'hA7;
  localparam logic [7:0] ADDR_HBC_LO    = 8'hA8;
  localparam logic [7:0] ADDR_HBC_HI    = 8'hA9;
  localparam logic [7:0] ADDR_VBC_LO    = 8'hAA;
  localparam logic [7:0] ADDR_VBC_HI    = 8'hAB;

  localparam logic [DISP_IDX_W-1:0] LINE_CMP_IDX = 5'd3;
  localparam logic [7:0] LINE_CMP_RESET = 8'hBB;
  localparam logic [7:0] MASKED_BITS    = 8'h3F;
  localparam logic [7:0] ID_COLOR       = 8'h87;
  localparam logic [7:0] ID_MONO        = 8'h86;
  localparam logic [7:0] GRAY_RESET     = 8'hFF;

  // Timer control bits
  localparam int unsigned TCTL_HB_EN   = 0;
  localparam int unsigned TCTL_HB_LOOP = 1;
  localparam int unsigned TCTL_VB_EN   = 2;
  localparam int unsigned TCTL_VB_LOOP = 3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] wdata;
  } in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       frame_done;
    logic       irq_vblank;
    logic       irq_hblank_timer;
    logic       irq_line_hit;
    logic       irq_vblank_timer;
  } out_t;

  typedef struct packed {
    logic wr_lo;
    logic wr_hi;
    logic load;
    logic step;
    logic en;
    logic loop;
  } tmr_ctrl_t;

endpackage

// File: design/drlt_timer.sv
// Countdown timer with a byte-writable 16-bit period, reload and loop mode.
module drlt_timer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  drlt_pkg::tmr_ctrl_t                 ctrl_i,
  input  logic [7:0]                          wdata_i,
  output logic [drlt_pkg::TMR_W-1:0]          period_o,
  output logic [drlt_pkg::TMR_W-1:0]          count_o,
  output logic                                expired_o
);

  logic [drlt_pkg::TMR_W-1:0] period_q, period_d;
  logic [drlt_pkg::TMR_W-1:0] count_q, count_d;
  logic [drlt_pkg::TMR_W-1:0] count_dec;

  assign count_dec = count_q - drlt_pkg::TMR_W'(1);

  always_comb begin
    period_d  = period_q;
    count_d   = count_q;
    expired_o = 1'b0;
    if (ctrl_i.wr_lo) begin
      period_d[7:0] = wdata_i;
    end
    if (ctrl_i.wr_hi) begin
      period_d[15:8] = wdata_i;
    end
    priority if (ctrl_i.wr_hi) begin
      count_d = period_d;
    end else if (ctrl_i.load) begin
      count_d = period_q;
    end else if (ctrl_i.step && ctrl_i.en && (count_q != '0)) begin
      count_d = count_dec;
      if (count_dec == '0) begin
        expired_o = 1'b1;
        if (ctrl_i.loop) begin
          count_d = period_q;
        end
      end
    end else begin
      // idle, disabled or already at zero: hold
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      count_q  <= '0;
    end else begin
      period_q <= period_d;
      count_q  <= count_d;
    end
  end

  assign period_o = period_q;
  assign count_o  = count_q;

endmodule

// File: design/display_regs_line_timers.sv
// Top level: display register file, scanline counter and the two line timers.
// A transaction that is taken lands in the input register, and its result is loaded
//   into the result register when that slot is free or being drained, one per cycle.
// The single state-update stage retires one item a cycle while the result is not stalled.
// Reset: asynchronous, active low; line counter to 145, line compare to 0xBB,
//   gray levels to full scale, other control and state registers, periods and counters to zero.
module display_regs_line_timers #(
  parameter int unsigned LINES_PER_FRAME = drlt_pkg::LinesPerFrameDef,
  parameter int unsigned VISIBLE_LINES   = drlt_pkg::VisibleLinesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  drlt_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output drlt_pkg::out_t out_o
);

  localparam int unsigned LW = drlt_pkg::LINE_W;

  // Model select register
  logic color_q;

  // Input stage
  logic          in_valid_q;
  drlt_pkg::in_t in_q;
  logic          advance;

  // Result stage
  logic           res_valid_q;
  drlt_pkg::out_t res_q, res_d;

  // Architectural state
  logic [LW-1:0]                line_q, line_d;
  logic [7:0]                   disp_q [drlt_pkg::DISP_DEPTH];
  logic [7:0]                   gray_q [drlt_pkg::GRAY_DEPTH];
  logic [drlt_pkg::PAL_W-1:0]   pal_q  [drlt_pkg::PAL_DEPTH];
  logic [7:0]                   vmode_q;
  logic [7:0]                   tctl_q;

  // Decoded item
  logic is_rd, is_wr, is_tick;
  logic in_gray, in_pal, in_disp;
  logic [drlt_pkg::DISP_IDX_W-1:0] disp_idx;

  // Timers
  drlt_pkg::tmr_ctrl_t         hb_ctrl, vb_ctrl;
  logic [drlt_pkg::TMR_W-1:0]  hb_period, hb_count, vb_period, vb_count;
  logic                        hb_expired, vb_expired;

  // Line arithmetic
  logic [LW:0]   line_inc;
  logic [LW-1:0] line_next;
  logic [7:0]    rd_data;
  logic [drlt_pkg::PAL_W-1:0] pal_rd;

  // ------------------------------------------------------------------
  // Handshake: the input register moves into the result register when
  // the result slot is free or being drained this cycle. The input side
  // stays open while a finished result waits, as long as the input
  // register is empty or can itself move on.
  // ------------------------------------------------------------------
  assign advance    = in_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      color_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // ------------------------------------------------------------------
  // Decode of the transaction in the input register
  // ------------------------------------------------------------------
  assign is_rd   = advance && (in_q.op == drlt_pkg::OP_READ);
  assign is_wr   = advance && (in_q.op == drlt_pkg::OP_WRITE);
  assign is_tick = advance && (in_q.op == drlt_pkg::OP_TICK);

  assign in_gray  = (in_q.addr[7:2] == drlt_pkg::ADDR_GRAY_HI);
  assign in_pal   = (in_q.addr[7:5] == drlt_pkg::ADDR_PAL_HI);
  assign in_disp  = (in_q.addr <= drlt_pkg::ADDR_DISP_LAST);
  assign disp_idx = in_q.addr[drlt_pkg::DISP_IDX_W-1:0];

  // ------------------------------------------------------------------
  // Line counter: wraps modulo LINES_PER_FRAME
  // ------------------------------------------------------------------
  assign line_inc  = {1'b0, line_q} + (LW+1)'(1);
  assign line_next = (line_inc == (LW+1)'(LINES_PER_FRAME)) ? '0 : line_inc[LW-1:0];
  assign line_d    = is_tick ? line_next : line_q;

  // ------------------------------------------------------------------
  // Timers. Enable rising edge and high-byte writes reload the counter.
  // The vblank timer only steps on wrap to line 0.
  // ------------------------------------------------------------------
  always_comb begin
    hb_ctrl.wr_lo = is_wr && (in_q.addr == drlt_pkg::ADDR_HB_LO);
    hb_ctrl.wr_hi = is_wr && (in_q.addr == drlt_pkg::ADDR_HB_HI);
    hb_ctrl.load  = is_wr && (in_q.addr == drlt_pkg::ADDR_TCTL) &&
                    in_q.wdata[drlt_pkg::TCTL_HB_EN] && !tctl_q[drlt_pkg::TCTL_HB_EN];
    hb_ctrl.step  = is_tick;
    hb_ctrl.en    = tctl_q[drlt_pkg::TCTL_HB_EN];
    hb_ctrl.loop  = tctl_q[drlt_pkg::TCTL_HB_LOOP];

    vb_ctrl.wr_lo = is_wr && (in_q.addr == drlt_pkg::ADDR_VB_LO);
    vb_ctrl.wr_hi = is_wr && (in_q.addr == drlt_pkg::ADDR_VB_HI);
    vb_ctrl.load  = is_wr && (in_q.addr == drlt_pkg::ADDR_TCTL) &&
                    in_q.wdata[drlt_pkg::TCTL_VB_EN] && !tctl_q[drlt_pkg::TCTL_VB_EN];
    vb_ctrl.step  = is_tick && (line_next == '0);
    vb_ctrl.en    = tctl_q[drlt_pkg::TCTL_VB_EN];
    vb_ctrl.loop  = tctl_q[drlt_pkg::TCTL_VB_LOOP];
  end

  drlt_timer u_hb_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hb_ctrl),
    .wdata_i   (in_q.wdata),
    .period_o  (hb_period),
    .count_o   (hb_count),
    .expired_o (hb_expired)
  );

  drlt_timer u_vb_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (vb_ctrl),
    .wdata_i   (in_q.wdata),
    .period_o  (vb_period),
    .count_o   (vb_count),
    .expired_o (vb_expired)
  );

  // ------------------------------------------------------------------
  // Register file writes. Gray levels are held in read-back form, one
  // byte per address. The line register is read only, and the byte
  // after line compare keeps its low six bits.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= drlt_pkg::LINE_RESET;
      vmode_q <= '0;
      tctl_q  <= '0;
      for (int i = 0; i < drlt_pkg::DISP_DEPTH; i++) begin
        disp_q[i] <= (i == int'(drlt_pkg::LINE_CMP_IDX)) ? drlt_pkg::LINE_CMP_RESET : '0;
      end
      for (int i = 0; i < drlt_pkg::GRAY_DEPTH; i++) begin
        gray_q[i] <= drlt_pkg::GRAY_RESET;
      end
      for (int i = 0; i < drlt_pkg::PAL_DEPTH; i++) begin
        pal_q[i] <= '0;
      end
    end else begin
      line_q <= line_d;
      if (is_wr) begin
        priority if (in_gray) begin
          gray_q[in_q.addr[1:0]] <= in_q.wdata;
        end else if (in_pal) begin
          pal_q[in_q.addr[4:0]] <= {in_q.wdata[6:4], in_q.wdata[2:0]};
        end else if (in_disp) begin
          if (in_q.addr == drlt_pkg::ADDR_MASKED) begin
            disp_q[disp_idx] <= in_q.wdata & drlt_pkg::MASKED_BITS;
          end else if (in_q.addr != drlt_pkg::ADDR_LINE) begin
            disp_q[disp_idx] <= in_q.wdata;
          end
        end else if (in_q.addr == drlt_pkg::ADDR_VMODE) begin
          vmode_q <= in_q.wdata;
        end else if (in_q.addr == drlt_pkg::ADDR_TCTL) begin
          tctl_q <= in_q.wdata;
        end else begin
          // read-only or unmapped: ignored
          tctl_q <= tctl_q;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Read mux
  // ------------------------------------------------------------------
  assign pal_rd = pal_q[in_q.addr[4:0]];

  always_comb begin
    priority if (in_gray) begin
      rd_data = gray_q[in_q.addr[1:0]];
    end else if (in_pal) begin
      rd_data = {1'b0, pal_rd[5:3], 1'b0, pal_rd[2:0]};
    end else if (in_disp) begin
      rd_data = (in_q.addr == drlt_pkg::ADDR_LINE) ? line_q : disp_q[disp_idx];
    end else begin
      unique case (in_q.addr)
        drlt_pkg::ADDR_VMODE:  rd_data = vmode_q;
        drlt_pkg::ADDR_ID:     rd_data = color_q ? drlt_pkg::ID_COLOR : drlt_pkg::ID_MONO;
        drlt_pkg::ADDR_TCTL:   rd_data = tctl_q;
        drlt_pkg::ADDR_HB_LO:  rd_data = hb_period[7:0];
        drlt_pkg::ADDR_HB_HI:  rd_data = hb_period[15:8];
        drlt_pkg::ADDR_VB_LO:  rd_data = vb_period[7:0];
        drlt_pkg::ADDR_VB_HI:  rd_data = vb_period[15:8];
        drlt_pkg::ADDR_HBC_LO: rd_data = hb_count[7:0];
        drlt_pkg::ADDR_HBC_HI: rd_data = hb_count[15:8];
        drlt_pkg::ADDR_VBC_LO: rd_data = vb_count[7:0];
        drlt_pkg::ADDR_VBC_HI: rd_data = vb_count[15:8];
        default:               rd_data = '0;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Result assembly. Flags only on ticks, read data only on reads.
  // ------------------------------------------------------------------
  always_comb begin
    res_d                  = '0;
    res_d.rdata            = is_rd ? rd_data : '0;
    res_d.frame_done       = is_tick && (line_q == LW'(VISIBLE_LINES));
    res_d.irq_vblank       = is_tick && (line_q == LW'(VISIBLE_LINES));
    res_d.irq_hblank_timer = is_tick && hb_expired;
    res_d.irq_line_hit     = is_tick && (line_next == disp_q[drlt_pkg::LINE_CMP_IDX]);
    res_d.irq_vblank_timer = is_tick && vb_expired;
  end

  assign out_valid_o = res_valid_q;
  assign out_o       = res_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q < LW'(LINES_PER_FRAME)) || (line_q == drlt_pkg::LINE_RESET))
    else $error("line counter out of range");

  a_no_flags_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.op != drlt_pkg::OP_TICK) |=>
      !res_q.frame_done && !res_q.irq_vblank && !res_q.irq_hblank_timer &&
      !res_q.irq_line_hit && !res_q.irq_vblank_timer)
    else $error("interrupt flag on a non-tick transaction");

  a_vbt_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.op == drlt_pkg::OP_TICK) |=>
      (!res_q.irq_vblank_timer || (line_q == '0)))
    else $error("vblank timer fired away from line 0");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("stalled input register lost its transaction");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_ready_i |=> res_valid_q && $stable(res_q))
    else $error("pending result overwritten");

endmodule
